FILE: hdl/imm_pkg.sv
`default_nettype none
package imm_pkg;

  localparam int DATA_W  = 16;
  localparam int IDX_W   = 6;
  localparam int DIM_W   = 7;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + DIM_W + 1;
  localparam int CFG_IDX_W = 2;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD_A = 2'd0;
  localparam op_t OP_LOAD_B = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_SAT   = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_SIZE = 2'd0;
  localparam cfg_index_t REG_ROWS = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/integer_matrix_multiply.sv
`default_nettype none
// Loads may follow back to back; busy stays low for them.
// A query keeps busy high through its issue, drain and finish states, and its result strobes
// in the first cycle with busy low again; an out-of-range query holds busy for one cycle.
// A query's length is set by the single read port of each store: one element pair and one
// multiply-accumulate per cycle. The receiver cannot stall, so nothing waits on it.
// Reset sets both registers to 64; the stores are not cleared and hold garbage until written.
module integer_matrix_multiply #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  operation,
  input  wire logic [imm_pkg::IDX_W-1:0]   row,
  input  wire logic [imm_pkg::IDX_W-1:0]   col,
  input  wire logic signed [imm_pkg::DATA_W-1:0] element_value,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [imm_pkg::DIM_W-1:0]   cfg_data,
  output logic                             result_valid,
  output logic [imm_pkg::IDX_W-1:0]        result_row,
  output logic [imm_pkg::IDX_W-1:0]        result_col,
  output logic signed [31:0]               product_value,
  output logic [1:0]                       status
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = imm_pkg::DIM_W;
  localparam int ACC_W  = imm_pkg::ACC_W;
  localparam logic [DIM_W-1:0] DIM_CAP =
    DIM_W'((MAX_DIM > 127) ? 127 : MAX_DIM);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_DIM);

  imm_pkg::state_t state, state_next;

  logic [DIM_W-1:0] size_reg;
  logic [DIM_W-1:0] rows_reg;
  logic [DIM_W-1:0] n_eff;
  logic [DIM_W-1:0] rows_eff;

  logic [DIM_W-1:0]  n_q;
  logic [DIM_W-1:0]  k;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [imm_pkg::IDX_W-1:0] q_row;
  logic [imm_pkg::IDX_W-1:0] q_col;
  logic q_err;

  logic rd_valid;
  logic prod_valid;
  logic signed [imm_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic accept;
  logic is_load;
  logic load_ok;
  logic range_err;
  logic re;
  logic [ADDR_W-1:0] load_addr;
  logic [imm_pkg::DATA_W-1:0] a_rdata;
  logic [imm_pkg::DATA_W-1:0] b_rdata;
  logic sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= 7'd64;
      rows_reg <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imm_pkg::REG_SIZE: size_reg <= cfg_data;
        imm_pkg::REG_ROWS: rows_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_reg == '0) begin
      n_eff = DIM_W'(1);
    end else if (size_reg > DIM_CAP) begin
      n_eff = DIM_CAP;
    end else begin
      n_eff = size_reg;
    end
    if (rows_reg == '0) begin
      rows_eff = DIM_W'(1);
    end else if (rows_reg > DIM_CAP) begin
      rows_eff = DIM_CAP;
    end else begin
      rows_eff = rows_reg;
    end
  end

  assign busy      = (state != imm_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign is_load   = (operation == imm_pkg::OP_LOAD_A) || (operation == imm_pkg::OP_LOAD_B);
  assign load_ok   = ({1'b0, row} < n_eff) && ({1'b0, col} < n_eff);
  assign range_err = ({1'b0, row} >= n_eff) || ({1'b0, row} >= rows_eff)
                     || ({1'b0, col} >= n_eff);
  assign load_addr = ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);

  imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) a_ram (
    .clk   (clk),
    .we    (accept && load_ok && (operation == imm_pkg::OP_LOAD_A)),
    .waddr (load_addr),
    .wdata (element_value),
    .re    (re),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) b_ram (
    .clk   (clk),
    .we    (accept && load_ok && (operation == imm_pkg::OP_LOAD_B)),
    .waddr (load_addr),
    .wdata (element_value),
    .re    (re),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  always_comb begin
    state_next = state;
    re = 1'b0;
    case (state)
      imm_pkg::ST_IDLE: begin
        if (accept && (operation == imm_pkg::OP_QUERY)) begin
          state_next = range_err ? imm_pkg::ST_FINISH : imm_pkg::ST_ISSUE;
        end
      end
      imm_pkg::ST_ISSUE: begin
        re = 1'b1;
        if (DIM_W'(k + 7'd1) == n_q) begin
          state_next = imm_pkg::ST_DRAIN;
        end
      end
      imm_pkg::ST_DRAIN: begin
        // The last product lands in the accumulator on the edge that leaves this state.
        if (!rd_valid) begin
          state_next = imm_pkg::ST_FINISH;
        end
      end
      imm_pkg::ST_FINISH: begin
        state_next = imm_pkg::ST_IDLE;
      end
      default: state_next = imm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= imm_pkg::ST_IDLE;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      rd_valid   <= re;
      prod_valid <= rd_valid;
      result_valid <= (state == imm_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_load) begin
      q_row  <= row;
      q_col  <= col;
      q_err  <= range_err;
      n_q    <= n_eff;
      k      <= '0;
      a_addr <= ADDR_W'(row) * ROW_STRIDE;
      b_addr <= ADDR_W'(col);
      acc    <= '0;
    end else begin
      if (re) begin
        k      <= DIM_W'(k + 7'd1);
        a_addr <= ADDR_W'(a_addr + ADDR_W'(1));
        b_addr <= ADDR_W'(b_addr + ROW_STRIDE);
      end
      if (prod_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (rd_valid) begin
      prod <= $signed(a_rdata) * $signed(b_rdata);
    end
  end

  // The sum fits in 32 bits exactly when all bits above bit 30 agree with the sign.
  assign sat = (acc[ACC_W-1:31] != '0) && (acc[ACC_W-1:31] != '1);

  always_ff @(posedge clk) begin
    if (state == imm_pkg::ST_FINISH) begin
      result_row <= q_row;
      result_col <= q_col;
      if (q_err) begin
        product_value <= '0;
        status        <= imm_pkg::ST_RANGE;
      end else if (sat) begin
        product_value <= acc[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        status        <= imm_pkg::ST_SAT;
      end else begin
        product_value <= acc[31:0];
        status        <= imm_pkg::ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/imm_ram.sv
`default_nettype none
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_integer_matrix_multiply.sv
`timescale 1ns / 100ps
module tb_integer_matrix_multiply;

  localparam int STORE_DIM = 64;
  localparam int QUIET_CYCLES = 70;
  localparam int STALL_LIMIT = 2000;
  localparam imm_pkg::op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    imm_pkg::op_t      op;
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [15:0] value;
  } mm_item_t;

  typedef struct packed {
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] product;
    imm_pkg::status_t   stat;
  } mm_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = imm_pkg::OP_LOAD_A;
  logic [5:0] row = 6'd0;
  logic [5:0] col = 6'd0;
  logic signed [15:0] element_value = 16'sd0;
  logic cfg_valid = 1'b0;
  imm_pkg::cfg_index_t cfg_index = imm_pkg::REG_SIZE;
  logic [6:0] cfg_data = 7'd0;

  logic busy;
  logic cfg_ready;
  logic result_valid;
  logic [5:0] result_row;
  logic [5:0] result_col;
  logic signed [31:0] product_value;
  logic [1:0] status;

  // Mirror of the block's registers and stores, used to compute product entries.
  logic [6:0] size_reg = 7'd64;
  logic [6:0] rows_reg = 7'd64;
  logic signed [15:0] a_mat [STORE_DIM*STORE_DIM];
  logic signed [15:0] b_mat [STORE_DIM*STORE_DIM];

  // Elements already loaded by the stimulus; queries never read anything else.
  bit a_written [STORE_DIM*STORE_DIM];
  bit b_written [STORE_DIM*STORE_DIM];

  mm_item_t  command_q [$];
  mm_entry_t pending_products [$];
  int work_items = 0;
  int gap_pct = 12;
  int mismatch_count = 0;
  int stall_cycles = 0;

  int size_plan [8] = '{0, 1, 5, 8, 13, 64, 127, 16};
  int rows_plan [8] = '{127, 1, 3, 8, 127, 64, 40, 0};
  int count_plan [8] = '{120, 80, 180, 200, 200, 250, 150, 80};

  integer_matrix_multiply i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .row           (row),
    .col           (col),
    .element_value (element_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_row    (result_row),
    .result_col    (result_col),
    .product_value (product_value),
    .status        (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int effective_dim(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'(STORE_DIM)) return STORE_DIM;
    return int'(v);
  endfunction

  function automatic void compute_product_entry(mm_item_t it);
    int n;
    int nr;
    longint acc;
    mm_entry_t e;
    n = effective_dim(size_reg);
    nr = effective_dim(rows_reg);
    case (it.op)
      imm_pkg::OP_LOAD_A: begin
        if (it.row < n && it.col < n) a_mat[it.row * STORE_DIM + it.col] = it.value;
      end
      imm_pkg::OP_LOAD_B: begin
        if (it.row < n && it.col < n) b_mat[it.row * STORE_DIM + it.col] = it.value;
      end
      imm_pkg::OP_QUERY: begin
        e.row = it.row;
        e.col = it.col;
        if (it.row >= n || it.row >= nr || it.col >= n) begin
          e.product = 32'sd0;
          e.stat = imm_pkg::ST_RANGE;
        end else begin
          acc = 0;
          for (int k = 0; k < n; k++)
            acc += longint'(a_mat[it.row * STORE_DIM + k]) *
                   longint'(b_mat[k * STORE_DIM + it.col]);
          if (acc > 64'sd2147483647) begin
            e.product = 32'sh7fffffff;
            e.stat = imm_pkg::ST_SAT;
          end else if (acc < -64'sd2147483648) begin
            e.product = 32'sh80000000;
            e.stat = imm_pkg::ST_SAT;
          end else begin
            e.product = acc[31:0];
            e.stat = imm_pkg::ST_OK;
          end
        end
        pending_products.push_back(e);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 100) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : driver
    mm_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) compute_product_entry(mm_item_t'{operation, row, col, element_value});
      if (!start || !busy) begin
        if (command_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = command_q.pop_front();
          start <= 1'b1;
          operation <= nxt.op;
          row <= nxt.row;
          col <= nxt.col;
          element_value <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    mm_entry_t want;
    if (!rst && result_valid) begin
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("unexpected word for C[%0d][%0d]", result_row, result_col));
      end else begin
        want = pending_products.pop_front();
        if (result_row !== want.row)
          report_mismatch($sformatf("result_row got %0d want %0d", result_row, want.row));
        if (result_col !== want.col)
          report_mismatch($sformatf("result_col got %0d want %0d", result_col, want.col));
        if (product_value !== want.product)
          report_mismatch($sformatf("C[%0d][%0d] product got %0d want %0d",
                                    want.row, want.col, product_value, want.product));
        if (status !== want.stat)
          report_mismatch($sformatf("C[%0d][%0d] status got %0d want %0d",
                                    want.row, want.col, status, want.stat));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[integer_matrix_multiply] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_register(imm_pkg::cfg_index_t idx, logic [6:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      imm_pkg::REG_SIZE: size_reg = value;
      imm_pkg::REG_ROWS: rows_reg = value;
      default: ;
    endcase
  endtask

  // Waits until every queued word is taken and every product entry has come back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (command_q.size() != 0 || start || busy || pending_products.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh8001;
        default: return 16'sh0000;
      endcase
    end
    if (r < 55) return 16'($urandom);
    return 16'(int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic void add_item(imm_pkg::op_t op, int r, int c, logic signed [15:0] v);
    int n;
    n = effective_dim(size_reg);
    command_q.push_back(mm_item_t'{op, 6'(r), 6'(c), v});
    if ((op == imm_pkg::OP_LOAD_A || op == imm_pkg::OP_LOAD_B) && r < n && c < n) begin
      if (op == imm_pkg::OP_LOAD_A) a_written[r * STORE_DIM + c] = 1'b1;
      else b_written[r * STORE_DIM + c] = 1'b1;
      work_items++;
    end else if (op == imm_pkg::OP_QUERY) begin
      work_items++;
    end
  endfunction

  // An in-range query first loads whatever part of its row and column is still unknown.
  function automatic void add_query(int r, int c);
    int n;
    int nr;
    n = effective_dim(size_reg);
    nr = effective_dim(rows_reg);
    if (r < n && r < nr && c < n) begin
      for (int k = 0; k < n; k++) begin
        if (!a_written[r * STORE_DIM + k]) add_item(imm_pkg::OP_LOAD_A, r, k, pick_value());
        if (!b_written[k * STORE_DIM + c]) add_item(imm_pkg::OP_LOAD_B, k, c, pick_value());
      end
    end
    add_item(imm_pkg::OP_QUERY, r, c, 16'($urandom));
  endfunction

  initial begin : stimulus
    int n;
    int live_rows;
    int target;
    int halfway;
    int pick;
    bit paused;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Small matrices with extreme elements: saturation both ways, range errors, ignored words.
    write_register(imm_pkg::REG_SIZE, 7'd3);
    write_register(imm_pkg::REG_ROWS, 7'd2);
    for (int k = 0; k < 3; k++) begin
      add_item(imm_pkg::OP_LOAD_A, 0, k, 16'sh8000);
      add_item(imm_pkg::OP_LOAD_B, k, 0, 16'sh8000);
      add_item(imm_pkg::OP_LOAD_B, k, 1, 16'sh7fff);
    end
    add_item(imm_pkg::OP_LOAD_A, 1, 0, 16'sd5);
    add_item(imm_pkg::OP_LOAD_A, 1, 1, 16'sd0);
    add_item(imm_pkg::OP_LOAD_A, 1, 2, -16'sd2);
    add_item(imm_pkg::OP_LOAD_A, 3, 0, 16'sh1234);
    add_item(imm_pkg::OP_LOAD_B, 63, 63, 16'shffff);
    add_item(OP_UNUSED, 63, 63, 16'shffff);
    add_query(0, 0);
    add_query(0, 1);
    add_query(1, 0);
    add_query(1, 1);
    add_query(2, 0);
    add_query(0, 3);
    add_query(63, 63);
    add_query(3, 1);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      write_register(imm_pkg::REG_SIZE, 7'(size_plan[p]));
      write_register(imm_pkg::REG_ROWS, 7'(rows_plan[p]));
      gap_pct = (p < 3) ? 12 : ((p < 6) ? 48 : 0);
      n = effective_dim(size_reg);
      live_rows = (n < effective_dim(rows_reg)) ? n : effective_dim(rows_reg);
      target = work_items + count_plan[p];
      halfway = work_items + count_plan[p] / 2;
      paused = 1'b0;
      while (work_items < target) begin
        if (!paused && work_items >= halfway) begin
          wait_quiet();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
          add_query($urandom_range(0, live_rows - 1), $urandom_range(0, n - 1));
        else if (pick < 62)
          add_query($urandom_range(0, 63), $urandom_range(0, 63));
        else if (pick < 88)
          add_item($urandom_range(0, 1) ? imm_pkg::OP_LOAD_B : imm_pkg::OP_LOAD_A,
                   $urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_value());
        else if (pick < 95)
          add_item($urandom_range(0, 1) ? imm_pkg::OP_LOAD_B : imm_pkg::OP_LOAD_A,
                   $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
        else
          add_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
      end
      wait_quiet();
    end

    if (mismatch_count == 0) begin
      $display("[integer_matrix_multiply] OK");
    end else begin
      $display("[integer_matrix_multiply] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/imm_pkg.sv
hdl/imm_ram.sv
hdl/integer_matrix_multiply.sv
tb/tb_integer_matrix_multiply.sv
